// ===== src/date_day_number_converter_assert.svh =====
// Assertion macros for the date day number converter.
// Needs clk_i and rst_ni in the module that includes this header.
`ifndef DATE_DAY_NUMBER_CONVERTER_ASSERT_SVH
`define DATE_DAY_NUMBER_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DDN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ddn_pkg.sv =====
// Shared types, widths and calendar helpers for the date day number converter.
// No dependencies.
package ddn_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_YFWD,
    S_MFWD,
    S_CHECK,
    S_SUM,
    S_RANGE,
    S_YBACK,
    S_MBACK
  } ddn_state_e;

  // Widths of the leap-rule cycle counters.
  localparam int unsigned C4W   = 2;
  localparam int unsigned C100W = 7;
  localparam int unsigned C400W = 9;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Leap year from the year's position in its 4, 100 and 400 year cycles.
  function automatic logic is_leap(input logic [C4W-1:0] c4, input logic [C100W-1:0] c100,
                                   input logic [C400W-1:0] c400);
    return ((c4 == '0) && (c100 != '0)) || (c400 == '0);
  endfunction

  // Month length; codes outside 1..12 give 30, as in the calendar table.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

  // Year length is 337 days plus February.
  function automatic logic [8:0] year_len(input logic leap);
    return 9'd337 + (leap ? 9'd29 : 9'd28);
  endfunction

endpackage

// ===== src/date_day_number_converter.sv =====
// Date day number converter, built on ddn_pkg and the assert header.
// The one add/subtract unit walks the years and then the months forward from the epoch,
// adds the day once it fits its month, adds the offset, checks the range and walks the
// years and months back; a bad year, month or zero day skips to the offset sum, and an
// out-of-range sum skips the walk back. A new date is taken only in idle; done_o cannot
// be stalled. rst_ni low returns the sequencer to idle.
`include "date_day_number_converter_assert.svh"

module date_day_number_converter #(
  parameter int EPOCH_YEAR = 1970,
  parameter int LAST_YEAR  = 2099
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [4:0]         in_day_i,
  input  logic [3:0]         in_month_i,
  input  logic [11:0]        in_year_i,
  input  logic signed [16:0] offset_days_i,
  output logic               done_o,
  output logic               date_valid_o,
  output logic [15:0]        day_number_o,
  output logic               out_of_range_o,
  output logic [4:0]         res_day_o,
  output logic [3:0]         res_month_o,
  output logic [11:0]        res_year_o
);

  // Leap days up to a year, counted at elaboration.
  localparam int LEAPS_LAST  = LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400;
  localparam int LEAPS_EPOCH = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                               + (EPOCH_YEAR - 1) / 400;
  localparam int MAXDAY = (LAST_YEAR - EPOCH_YEAR + 1) * 365 + LEAPS_LAST - LEAPS_EPOCH;
  localparam int NW     = $clog2(MAXDAY + 1);
  localparam int AW     = ((NW > 16) ? NW : 16) + 2;

  localparam logic signed [AW-1:0] MAX_S = AW'(MAXDAY);
  localparam logic [11:0] EPOCH_Y = 12'(EPOCH_YEAR);
  localparam logic [11:0] LAST_Y  = 12'(LAST_YEAR);
  localparam logic [ddn_pkg::C4W-1:0]   C4_INIT   = ddn_pkg::C4W'(EPOCH_YEAR % 4);
  localparam logic [ddn_pkg::C100W-1:0] C100_INIT = ddn_pkg::C100W'(EPOCH_YEAR % 100);
  localparam logic [ddn_pkg::C400W-1:0] C400_INIT = ddn_pkg::C400W'(EPOCH_YEAR % 400);

  ddn_pkg::ddn_state_e state_q, state_d;

  logic [4:0]                 day_q;
  logic [3:0]                 mon_q;
  logic [11:0]                yin_q;
  logic signed [16:0]         off_q;
  logic [11:0]                yr_q;
  logic [3:0]                 m_q;
  logic [ddn_pkg::C4W-1:0]    c4_q;
  logic [ddn_pkg::C100W-1:0]  c100_q;
  logic [ddn_pkg::C400W-1:0]  c400_q;
  logic signed [AW-1:0]       acc_q;
  logic                       valid_q;
  logic                       oor_q;
  logic [15:0]                num_q;

  logic                 leap;
  logic [8:0]           len;
  logic                 sub;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] alu;
  logic                 alu_pos;
  logic                 in_ok;
  logic                 year_more;
  logic                 month_more;
  logic                 range_bad;

  // Shared add/subtract unit: adds a year or month length walking forward, the day and
  // then the offset, and subtracts a length walking back; the sign is the compare.
  always_comb begin
    leap = ddn_pkg::is_leap(c4_q, c100_q, c400_q);
    if ((state_q == ddn_pkg::S_YFWD) || (state_q == ddn_pkg::S_YBACK)) begin
      len = ddn_pkg::year_len(leap);
    end else begin
      len = {4'd0, ddn_pkg::month_len(m_q, leap)};
    end
    sub = (state_q == ddn_pkg::S_YBACK) || (state_q == ddn_pkg::S_MBACK);
    if (state_q == ddn_pkg::S_CHECK) begin
      addend = $signed(AW'(day_q));
    end else if (state_q == ddn_pkg::S_SUM) begin
      addend = AW'(off_q);
    end else begin
      addend = sub ? -$signed(AW'(len)) : $signed(AW'(len));
    end
    alu     = acc_q + addend;
    alu_pos = !alu[AW-1] && (alu != '0);
  end

  // Decisions of the sequencer.
  always_comb begin
    in_ok = (in_year_i >= EPOCH_Y) && (in_year_i <= LAST_Y) && (in_month_i >= 4'd1)
            && (in_month_i <= ddn_pkg::MONTH_DEC) && (in_day_i != 5'd0);
    year_more  = yr_q < yin_q;
    month_more = m_q < mon_q;
    range_bad  = (acc_q <= $signed(AW'(0))) || (acc_q > MAX_S);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ddn_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = in_ok ? ddn_pkg::S_YFWD : ddn_pkg::S_SUM;
        end
      end
      ddn_pkg::S_YFWD: begin
        if (!year_more) begin
          state_d = ddn_pkg::S_MFWD;
        end
      end
      ddn_pkg::S_MFWD: begin
        if (!month_more) begin
          state_d = ddn_pkg::S_CHECK;
        end
      end
      ddn_pkg::S_CHECK: state_d = ddn_pkg::S_SUM;
      ddn_pkg::S_SUM:   state_d = ddn_pkg::S_RANGE;
      ddn_pkg::S_RANGE: state_d = range_bad ? ddn_pkg::S_MBACK : ddn_pkg::S_YBACK;
      ddn_pkg::S_YBACK: begin
        if (!alu_pos) begin
          state_d = ddn_pkg::S_MBACK;
        end
      end
      ddn_pkg::S_MBACK: begin
        if (oor_q || (m_q >= ddn_pkg::MONTH_DEC) || !alu_pos) begin
          state_d = ddn_pkg::S_IDLE;
        end
      end
      default: state_d = ddn_pkg::S_IDLE;
    endcase
  end

  // Outputs: the result beat is shown in the last month-back cycle.
  always_comb begin
    busy_o         = (state_q != ddn_pkg::S_IDLE);
    done_o         = 1'b0;
    if (state_q == ddn_pkg::S_MBACK) begin
      done_o = oor_q || (m_q >= ddn_pkg::MONTH_DEC) || !alu_pos;
    end
    date_valid_o   = valid_q;
    day_number_o   = num_q;
    out_of_range_o = oor_q;
    res_day_o      = oor_q ? 5'd0 : acc_q[4:0];
    res_month_o    = oor_q ? 4'd0 : m_q;
    res_year_o     = oor_q ? 12'd0 : yr_q;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddn_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ddn_pkg::S_IDLE: begin
        day_q   <= in_day_i;
        mon_q   <= in_month_i;
        yin_q   <= in_year_i;
        off_q   <= offset_days_i;
        yr_q    <= EPOCH_Y;
        m_q     <= 4'd1;
        c4_q    <= C4_INIT;
        c100_q  <= C100_INIT;
        c400_q  <= C400_INIT;
        acc_q   <= '0;
        valid_q <= in_ok;
      end
      ddn_pkg::S_YFWD: begin
        if (year_more) begin
          acc_q  <= alu;
          yr_q   <= yr_q + 12'd1;
          c4_q   <= c4_q + 1'b1;
          c100_q <= (c100_q == ddn_pkg::C100W'(99)) ? '0 : c100_q + 1'b1;
          c400_q <= (c400_q == ddn_pkg::C400W'(399)) ? '0 : c400_q + 1'b1;
        end
      end
      ddn_pkg::S_MFWD: begin
        if (month_more) begin
          acc_q <= alu;
          m_q   <= m_q + 4'd1;
        end
      end
      ddn_pkg::S_CHECK: begin
        // Here m_q equals the input month and the counters match the input year.
        if ({4'd0, day_q} > len) begin
          valid_q <= 1'b0;
          acc_q   <= '0;
        end else begin
          acc_q <= alu;
        end
      end
      ddn_pkg::S_SUM: begin
        num_q <= acc_q[15:0];
        acc_q <= alu;
      end
      ddn_pkg::S_RANGE: begin
        oor_q  <= range_bad;
        yr_q   <= EPOCH_Y;
        m_q    <= 4'd1;
        c4_q   <= C4_INIT;
        c100_q <= C100_INIT;
        c400_q <= C400_INIT;
      end
      ddn_pkg::S_YBACK: begin
        if (alu_pos) begin
          acc_q  <= alu;
          yr_q   <= yr_q + 12'd1;
          c4_q   <= c4_q + 1'b1;
          c100_q <= (c100_q == ddn_pkg::C100W'(99)) ? '0 : c100_q + 1'b1;
          c400_q <= (c400_q == ddn_pkg::C400W'(399)) ? '0 : c400_q + 1'b1;
        end
      end
      ddn_pkg::S_MBACK: begin
        if (!oor_q && (m_q < ddn_pkg::MONTH_DEC) && alu_pos) begin
          acc_q <= alu;
          m_q   <= m_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks on the sequencer and the result beat.
  `DDN_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted beat did not raise busy")
  `DDN_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy_o, "result strobe lasted too long")
  `DDN_ASSERT_NOW(a_oor_zero, done_o && out_of_range_o,
    (res_day_o == 5'd0) && (res_month_o == 4'd0) && (res_year_o == 12'd0),
    "out of range result has nonzero date")
  `DDN_ASSERT_NOW(a_invalid_zero, done_o && !date_valid_o, day_number_o == 16'd0,
    "invalid date has nonzero day number")

endmodule

// ===== verif/date_day_number_converter_test.sv =====
// Self-checking testbench for date_day_number_converter: a table of directed dates, then
// random well-formed and broken dates, scored against given results or a calendar predictor in this file.
// Depends only on the RTL in src (the block, its package and its assertion header).
module date_day_number_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EPOCH_YEAR = 1970;
  localparam int LAST_YEAR = 2099;
  // Day number of 31 December of the last year, counted from 1 January of the epoch year.
  localparam int LAST_DAY_NUMBER = 47482;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;

  // One result beat, in port order.
  typedef struct packed {
    logic        valid;
    logic [15:0] number;
    logic        oor;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } shifted_date_t;

  // One row of the directed table; the result is typed in only where known is set.
  typedef struct packed {
    logic          known;
    logic [4:0]    day;
    logic [3:0]    month;
    logic [11:0]   year;
    logic [16:0]   offset;
    shifted_date_t result;
  } date_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam date_row_t DATE_TABLE [DIRECTED_ROWS] = '{
    // Both ends of the calendar, with and without a shift across the whole span.
    '{1'b1, 5'd1, 4'd1, 12'd1970, 17'd0, '{1'b1, 16'd1, 1'b0, 5'd1, 4'd1, 12'd1970}},
    '{1'b1, 5'd31, 4'd12, 12'd2099, 17'd0, '{1'b1, 16'd47482, 1'b0, 5'd31, 4'd12, 12'd2099}},
    '{1'b1, 5'd1, 4'd1, 12'd1970, -17'sd1, '{1'b1, 16'd1, 1'b1, 5'd0, 4'd0, 12'd0}},
    '{1'b1, 5'd31, 4'd12, 12'd2099, 17'd1, '{1'b1, 16'd47482, 1'b1, 5'd0, 4'd0, 12'd0}},
    '{1'b1, 5'd1, 4'd1, 12'd1970, 17'd47481, '{1'b1, 16'd1, 1'b0, 5'd31, 4'd12, 12'd2099}},
    '{1'b1, 5'd31, 4'd12, 12'd2099, -17'sd47481, '{1'b1, 16'd47482, 1'b0, 5'd1, 4'd1, 12'd1970}},
    // Invalid dates count as day zero, and the shift still applies.
    '{1'b1, 5'd0, 4'd1, 12'd1970, 17'd0, '{1'b0, 16'd0, 1'b1, 5'd0, 4'd0, 12'd0}},
    '{1'b1, 5'd0, 4'd0, 12'd0, 17'd47482, '{1'b0, 16'd0, 1'b0, 5'd31, 4'd12, 12'd2099}},
    '{1'b1, 5'd1, 4'd1, 12'd1969, 17'd5, '{1'b0, 16'd0, 1'b0, 5'd5, 4'd1, 12'd1970}},
    '{1'b1, 5'd1, 4'd1, 12'd2100, 17'd1, '{1'b0, 16'd0, 1'b0, 5'd1, 4'd1, 12'd1970}},
    '{1'b1, 5'd1, 4'd13, 12'd2000, 17'd0, '{1'b0, 16'd0, 1'b1, 5'd0, 4'd0, 12'd0}},
    '{1'b1, 5'd31, 4'd15, 12'd4095, 17'h10000, '{1'b0, 16'd0, 1'b1, 5'd0, 4'd0, 12'd0}},
    '{1'b1, 5'd31, 4'd15, 12'd4095, 17'h0FFFF, '{1'b0, 16'd0, 1'b1, 5'd0, 4'd0, 12'd0}},
    '{1'b1, 5'd1, 4'd0, 12'd2000, 17'd1, '{1'b0, 16'd0, 1'b0, 5'd1, 4'd1, 12'd1970}},
    '{1'b1, 5'd29, 4'd2, 12'd2001, 17'd0, '{1'b0, 16'd0, 1'b1, 5'd0, 4'd0, 12'd0}},
    '{1'b1, 5'd31, 4'd4, 12'd2020, 17'd0, '{1'b0, 16'd0, 1'b1, 5'd0, 4'd0, 12'd0}},
    '{1'b1, 5'd1, 4'd3, 12'd2100, -17'sd59, '{1'b0, 16'd0, 1'b1, 5'd0, 4'd0, 12'd0}},
    // Leap days, month and year turns; these go to the predictor.
    '{1'b0, 5'd29, 4'd2, 12'd2000, 17'd0, '0},
    '{1'b0, 5'd29, 4'd2, 12'd2096, 17'd1, '0},
    '{1'b0, 5'd30, 4'd4, 12'd2020, 17'd1, '0},
    '{1'b0, 5'd28, 4'd2, 12'd1970, 17'd1, '0},
    '{1'b0, 5'd31, 4'd12, 12'd1999, 17'd1, '0},
    '{1'b0, 5'd15, 4'd6, 12'd2050, -17'sd100, '0},
    '{1'b0, 5'd31, 4'd12, 12'd2098, 17'd365, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [4:0]         in_day_i;
  logic [3:0]         in_month_i;
  logic [11:0]        in_year_i;
  logic signed [16:0] offset_days_i;
  logic               done_o;
  logic               date_valid_o;
  logic [15:0]        day_number_o;
  logic               out_of_range_o;
  logic [4:0]         res_day_o;
  logic [3:0]         res_month_o;
  logic [11:0]        res_year_o;

  shifted_date_t expected_dates[$];
  int faults = 0;
  int dates_sent = 0;
  int dates_checked = 0;
  int valid_seen = 0;
  int oor_seen = 0;
  int idle_cycles = 0;

  date_day_number_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .in_day_i      (in_day_i),
    .in_month_i    (in_month_i),
    .in_year_i     (in_year_i),
    .offset_days_i (offset_days_i),
    .done_o        (done_o),
    .date_valid_o  (date_valid_o),
    .day_number_o  (day_number_o),
    .out_of_range_o(out_of_range_o),
    .res_day_o     (res_day_o),
    .res_month_o   (res_month_o),
    .res_year_o    (res_year_o)
  );

  // Gregorian leap rule.
  function automatic bit leap_rule(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Days in a month; codes outside 1..12 fall through to 30.
  function automatic int month_days(int m, int y);
    case (m)
      2: return leap_rule(y) ? 29 : 28;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default: return 30;
    endcase
  endfunction

  function automatic int year_days(int y);
    return 337 + (leap_rule(y) ? 29 : 28);
  endfunction

  // Days of the year that lie before the first of month m.
  function automatic int days_ahead(int m, int y);
    int acc;
    acc = 0;
    for (int i = 1; i < m && i <= 12; i++) acc += month_days(i, y);
    return acc;
  endfunction

  // Validates the date, numbers it, adds the shift and walks years then months back.
  function automatic shifted_date_t shift_date(int d, int m, int y, int off);
    shifted_date_t r;
    int num;
    int sum;
    int rest;
    int yy;
    int mm;
    r = '0;
    num = 0;
    r.valid = y >= EPOCH_YEAR && y <= LAST_YEAR && m >= 1 && m <= 12 &&
              d >= 1 && d <= month_days(m, y);
    if (r.valid) begin
      for (yy = EPOCH_YEAR; yy < y; yy++) num += year_days(yy);
      num += days_ahead(m, y) + d;
    end
    sum = num + off;
    r.number = num[15:0];
    r.oor = sum < 1 || sum > LAST_DAY_NUMBER;
    if (!r.oor) begin
      rest = sum;
      yy = EPOCH_YEAR;
      while (rest > year_days(yy)) begin
        rest -= year_days(yy);
        yy++;
      end
      mm = 1;
      while (mm < 12 && rest > days_ahead(mm + 1, yy)) mm++;
      r.day = 5'(rest - days_ahead(mm, yy));
      r.month = 4'(mm);
      r.year = 12'(yy);
    end
    return r;
  endfunction

  // Mostly back-to-back beats, some short gaps, a few long ones, and bursts with none.
  function automatic int pick_gap(int idx);
    int r;
    if (idx % 300 < 50) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drives one date beat at the falling edge and holds it until the block takes it.
  task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [11:0] y,
                           input logic [16:0] off, input bit known,
                           input shifted_date_t given, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_day_i <= d;
    in_month_i <= m;
    in_year_i <= y;
    offset_days_i <= off;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    expected_dates.push_back(known ? given : shift_date(d, m, y, $signed(off)));
    dates_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Score every result beat against the oldest expectation and guard against hangs.
  always @(posedge clk_i) begin : result_check
    shifted_date_t got;
    shifted_date_t want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (done_o) begin
        got = '{date_valid_o, day_number_o, out_of_range_o, res_day_o, res_month_o,
                res_year_o};
        if (expected_dates.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("%t: result beat with nothing expected: %p", $realtime, got);
        end else begin
          want = expected_dates.pop_front();
          dates_checked++;
          if (want.valid) valid_seen++;
          if (want.oor) oor_seen++;
          if (got !== want) begin
            faults++;
            if (faults <= REPORT_LIMIT)
              $display("%t: mismatch valid %b/%b number %0d/%0d oor %b/%b date %0d-%0d-%0d/%0d-%0d-%0d",
                       $realtime, want.valid, got.valid, want.number, got.number,
                       want.oor, got.oor, want.year, want.month, want.day,
                       got.year, got.month, got.day);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d idle cycles with %0d results pending.", idle_cycles,
                 expected_dates.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus: the directed table first, then random dates.
  initial begin
    int kind;
    int d;
    int m;
    int y;
    int target;
    int number;
    bit raw_shift;
    logic [16:0] off;
    shifted_date_t probe;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_day_i = '0;
    in_month_i = '0;
    in_year_i = '0;
    offset_days_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_date(DATE_TABLE[i].day, DATE_TABLE[i].month, DATE_TABLE[i].year,
                DATE_TABLE[i].offset, DATE_TABLE[i].known, DATE_TABLE[i].result,
                pick_gap(i + 50));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      y = $urandom_range(EPOCH_YEAR, LAST_YEAR);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, month_days(m, y));
      target = $urandom_range(1, LAST_DAY_NUMBER);
      raw_shift = 1'b0;
      if (kind < 60) begin
        // Valid date shifted to a random day inside the calendar.
      end else if (kind < 70) begin
        // Valid date shifted onto an edge of the calendar or a new year.
        case ($urandom_range(0, 3))
          0: target = $urandom_range(1, 3);
          1: target = LAST_DAY_NUMBER - $urandom_range(0, 2);
          default: begin
            probe = shift_date(1, 1, $urandom_range(EPOCH_YEAR, LAST_YEAR), 0);
            target = int'(probe.number) - int'($urandom_range(0, 1));
          end
        endcase
      end else if (kind < 78) begin
        raw_shift = 1'b1;
      end else if (kind < 85) begin
        // Valid date shifted just past either end.
        target = $urandom_range(0, 1) ? 1 - $urandom_range(1, 40)
                                      : LAST_DAY_NUMBER + $urandom_range(1, 40);
      end else if (kind < 92) begin
        // Broken date: day zero, a day past the month end, or a leap day in any year.
        case ($urandom_range(0, 2))
          0: d = 0;
          1: d = $urandom_range(month_days(m, y) + 1, 31);
          default: begin
            m = 2;
            d = 29;
          end
        endcase
      end else begin
        // Any bit pattern at all.
        d = $urandom_range(0, 31);
        m = $urandom_range(0, 15);
        y = $urandom_range(0, 4095);
        raw_shift = 1'b1;
      end
      probe = shift_date(d, m, y, 0);
      number = int'(probe.number);
      off = raw_shift ? 17'($urandom) : 17'(target - number);
      send_date(5'(d), 4'(m), 12'(y), off, 1'b0, '0, pick_gap(i));
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Sent %0d dates and checked %0d results: %0d valid inputs, %0d out of range.",
             dates_sent, dates_checked, valid_seen, oor_seen);
    if (faults == 0 && expected_dates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d faults, %0d results missing.", faults, expected_dates.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ddn_pkg.sv
src/date_day_number_converter.sv
verif/date_day_number_converter_test.sv
